// ===== sv/spq_pkg.sv =====
`timescale 1ns / 1ps
// Package for the shared-pool egress queue: sizes, status codes, modes, states.
// No dependencies.
package spq_pkg;
    localparam int SLOT_COUNT      = 64;
    localparam int CHANNEL_COUNT   = 16;
    localparam int PER_CHANNEL_CAP = 16;
    localparam int MAX_FRAME_BYTES = 8;
    localparam int SW = $clog2(SLOT_COUNT);
    localparam int PW = SW + 1;
    localparam int CW = 4;
    localparam int QCW = $clog2(PER_CHANNEL_CAP + 1);
    localparam logic [PW-1:0] NIL = PW'(SLOT_COUNT);

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_GRANT = 2'd2,
        MODE_FRONT = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_QUEUED      = 3'd0,
        ST_EVICT_OWN   = 3'd1,
        ST_EVICT_OTHER = 3'd2,
        ST_DROPPED     = 3'd3,
        ST_DONE        = 3'd4,
        ST_EMPTY       = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN, S_TAKE, S_LINK, S_FREE, S_FILL, S_APPEND,
        S_READ, S_RDATA, S_OUT
    } state_t;
endpackage

// ===== sv/shared_pool_multichannel_egress_queue.sv =====
`timescale 1ns / 1ps
// Shared-pool multichannel egress queue: 16 channel FIFOs linked through one pool
// of 64 frame slots with a free list. A sequencer walks one beat through the slot
// link memory and the frame memory state by state; stall stays high while busy.
// A dropped push or an empty pop or front read goes straight to the output state;
// a pop or front read first reads the head slot, a push takes a free slot or an
// evicted head and links it to the tail, and a grant or a push into a full pool
// first runs the channel scan. The result sits in its own output register, so a
// stalled result holds the sequencer only in its output state. After reset the
// link memory is initialized over all 64 slots before the first beat is taken.
// Depends on spq_pkg and spq_scan.
module shared_pool_multichannel_egress_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [3:0]  channel,
    input  logic [63:0] payload,
    input  logic [3:0]  frame_size,
    input  logic [63:0] timestamp,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [3:0]  victim_channel,
    output logic [3:0]  granted_channel,
    output logic [63:0] front_payload,
    output logic [3:0]  front_size,
    output logic [63:0] front_time,
    output logic        any_pending,
    output logic        channel_pending
);
    localparam int SW  = spq_pkg::SW;
    localparam int PW  = spq_pkg::PW;
    localparam int CW  = spq_pkg::CW;
    localparam int QCW = spq_pkg::QCW;
    localparam int NCH = spq_pkg::CHANNEL_COUNT;
    localparam int UW  = $clog2(spq_pkg::SLOT_COUNT + 1);

    // link, payload, length, time memories
    logic [PW-1:0] link_mem [spq_pkg::SLOT_COUNT];
    logic [63:0]   pay_mem  [spq_pkg::SLOT_COUNT];
    logic [3:0]    len_mem  [spq_pkg::SLOT_COUNT];
    logic [63:0]   time_mem [spq_pkg::SLOT_COUNT];

    spq_pkg::state_t state_reg, state_next;
    logic [NCH-1:0][PW-1:0]  qhead_reg, qhead_next;
    logic [NCH-1:0][PW-1:0]  qtail_reg, qtail_next;
    logic [NCH-1:0][QCW-1:0] qcnt_reg, qcnt_next;
    logic [PW-1:0] free_reg, free_next;
    logic [UW-1:0] used_reg, used_next;
    logic [CW-1:0] cursor_reg, cursor_next;
    logic [PW-1:0] init_reg, init_next;

    logic [1:0]  mode_reg, mode_next;
    logic [CW-1:0] ch_reg, ch_next;
    logic [63:0] pay_reg, pay_next;
    logic [3:0]  len_reg, len_next;
    logic [63:0] ts_reg, ts_next;
    logic [CW-1:0] victim_reg, victim_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [2:0]  st_reg, st_next;
    logic [CW-1:0] ev_reg, ev_next, gr_reg, gr_next;
    logic [63:0] fp_reg, fp_next, ft_reg, ft_next;
    logic [3:0]  fs_reg, fs_next;
    logic        tail_link_reg, tail_link_next;
    logic        ovalid_reg, ovalid_next;
    logic        anyp_reg, anyp_next, chp_reg, chp_next;
    logic [2:0]  ost_reg, ost_next;
    logic [CW-1:0] oev_reg, oev_next, ogr_reg, ogr_next;
    logic [63:0] ofp_reg, ofp_next, oft_reg, oft_next;
    logic [3:0]  ofs_reg, ofs_next;

    // link read port
    logic [SW-1:0] lrd_addr;
    logic [PW-1:0] lrd_data;
    logic          lwr_en;
    logic [SW-1:0] lwr_addr;
    logic [PW-1:0] lwr_data;
    logic          fwr_en;
    logic [SW-1:0] frd_addr;
    logic [63:0]   frd_pay, frd_time;
    logic [3:0]    frd_len;
    logic [63:0]   fill_mask;

    logic          scan_start, scan_max, scan_done, scan_found;
    logic [CW-1:0] scan_res;

    spq_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .find_max(scan_max),
        .cursor  (cursor_reg),
        .counts  (qcnt_reg),
        .done    (scan_done),
        .found   (scan_found),
        .result  (scan_res)
    );

    always_ff @(posedge clk)
    begin
        if (lwr_en)
            link_mem[lwr_addr] <= lwr_data;
        lrd_data <= link_mem[lrd_addr];
        if (fwr_en)
        begin
            pay_mem[slot_reg]  <= pay_reg & fill_mask;
            len_mem[slot_reg]  <= len_reg;
            time_mem[slot_reg] <= ts_reg;
        end
        frd_pay  <= pay_mem[frd_addr];
        frd_len  <= len_mem[frd_addr];
        frd_time <= time_mem[frd_addr];
    end

    always_comb
    begin
        fill_mask = '1;
        if (len_reg < 4'd8)
            fill_mask = (64'd1 << {len_reg[2:0], 3'b000}) - 64'd1;
    end

    logic [CW-1:0] take_ch;
    assign take_ch = (st_reg == spq_pkg::ST_EVICT_OTHER) ? victim_reg : ch_reg;

    always_comb
    begin
        state_next  = state_reg;
        qhead_next  = qhead_reg;
        qtail_next  = qtail_reg;
        qcnt_next   = qcnt_reg;
        free_next   = free_reg;
        used_next   = used_reg;
        cursor_next = cursor_reg;
        init_next   = init_reg;
        mode_next   = mode_reg;
        ch_next     = ch_reg;
        pay_next    = pay_reg;
        len_next    = len_reg;
        ts_next     = ts_reg;
        victim_next = victim_reg;
        slot_next   = slot_reg;
        st_next     = st_reg;
        ev_next     = ev_reg;
        gr_next     = gr_reg;
        fp_next     = fp_reg;
        fs_next     = fs_reg;
        ft_next     = ft_reg;
        tail_link_next = tail_link_reg;
        ovalid_next = ovalid_reg;
        anyp_next   = anyp_reg;
        chp_next    = chp_reg;
        ost_next    = ost_reg;
        oev_next    = oev_reg;
        ogr_next    = ogr_reg;
        ofp_next    = ofp_reg;
        ofs_next    = ofs_reg;
        oft_next    = oft_reg;
        lrd_addr    = slot_reg;
        lwr_en      = 1'b0;
        lwr_addr    = slot_reg;
        lwr_data    = spq_pkg::NIL;
        fwr_en      = 1'b0;
        frd_addr    = slot_reg;
        scan_start  = 1'b0;
        scan_max    = 1'b0;
        in_stall    = 1'b1;

        if (ovalid_reg && !out_stall)
            ovalid_next = 1'b0;

        case (state_reg)
            spq_pkg::S_INIT:
            begin
                lwr_en    = 1'b1;
                lwr_addr  = init_reg[SW-1:0];
                lwr_data  = init_reg + 1'b1;
                init_next = init_reg + 1'b1;
                if (init_reg == PW'(spq_pkg::SLOT_COUNT - 1))
                    state_next = spq_pkg::S_IDLE;
            end
            spq_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    mode_next = mode;
                    ch_next   = channel;
                    pay_next  = payload;
                    len_next  = frame_size;
                    ts_next   = timestamp;
                    st_next   = spq_pkg::ST_EMPTY;
                    ev_next   = '0;
                    gr_next   = '0;
                    fp_next   = '0;
                    fs_next   = '0;
                    ft_next   = '0;
                    state_next = spq_pkg::S_OUT;
                    case (spq_pkg::mode_t'(mode))
                        spq_pkg::MODE_PUSH:
                        begin
                            if (frame_size > 4'(spq_pkg::MAX_FRAME_BYTES))
                                st_next = spq_pkg::ST_DROPPED;
                            else if (qcnt_reg[channel] >= QCW'(spq_pkg::PER_CHANNEL_CAP))
                            begin
                                st_next    = spq_pkg::ST_EVICT_OWN;
                                ev_next    = channel;
                                slot_next  = qhead_reg[channel][SW-1:0];
                                state_next = spq_pkg::S_TAKE;
                            end
                            else if (free_reg != spq_pkg::NIL)
                            begin
                                st_next    = spq_pkg::ST_QUEUED;
                                slot_next  = free_reg[SW-1:0];
                                state_next = spq_pkg::S_FREE;
                            end
                            else
                            begin
                                st_next    = spq_pkg::ST_EVICT_OTHER;
                                scan_start = 1'b1;
                                scan_max   = 1'b1;
                                state_next = spq_pkg::S_SCAN;
                            end
                        end
                        spq_pkg::MODE_POP:
                        begin
                            if (qhead_reg[channel] != spq_pkg::NIL)
                            begin
                                st_next    = spq_pkg::ST_DONE;
                                slot_next  = qhead_reg[channel][SW-1:0];
                                state_next = spq_pkg::S_TAKE;
                            end
                        end
                        spq_pkg::MODE_GRANT:
                        begin
                            scan_start = 1'b1;
                            state_next = spq_pkg::S_SCAN;
                        end
                        default:
                        begin
                            if (qhead_reg[channel] != spq_pkg::NIL)
                            begin
                                slot_next  = qhead_reg[channel][SW-1:0];
                                state_next = spq_pkg::S_READ;
                            end
                        end
                    endcase
                end
            end
            spq_pkg::S_SCAN:
            begin
                if (scan_done)
                begin
                    if (mode_reg == spq_pkg::MODE_GRANT)
                    begin
                        state_next = spq_pkg::S_OUT;
                        if (scan_found)
                        begin
                            st_next     = spq_pkg::ST_DONE;
                            gr_next     = scan_res;
                            cursor_next = (scan_res == CW'(NCH - 1)) ? '0 : scan_res + 1'b1;
                        end
                    end
                    else
                    begin
                        victim_next = scan_res;
                        ev_next     = scan_res;
                        slot_next   = qhead_reg[scan_res][SW-1:0];
                        state_next  = spq_pkg::S_TAKE;
                    end
                end
            end
            spq_pkg::S_TAKE:
            begin
                // read the head's link
                lrd_addr   = slot_reg;
                state_next = spq_pkg::S_LINK;
            end
            spq_pkg::S_LINK:
            begin
                qhead_next[take_ch] = lrd_data;
                if (lrd_data == spq_pkg::NIL)
                    qtail_next[take_ch] = spq_pkg::NIL;
                qcnt_next[take_ch] = qcnt_reg[take_ch] - 1'b1;
                if (mode_reg == spq_pkg::MODE_POP)
                begin
                    lwr_en     = 1'b1;
                    lwr_data   = free_reg;
                    free_next  = {1'b0, slot_reg};
                    used_next  = used_reg - 1'b1;
                    state_next = spq_pkg::S_OUT;
                end
                else
                    state_next = spq_pkg::S_FILL;
            end
            spq_pkg::S_FREE:
            begin
                lrd_addr   = slot_reg;
                state_next = spq_pkg::S_APPEND;
            end
            spq_pkg::S_APPEND:
            begin
                // pop from free list, then fill
                free_next  = lrd_data;
                used_next  = used_reg + 1'b1;
                state_next = spq_pkg::S_FILL;
            end
            spq_pkg::S_FILL:
            begin
                fwr_en = 1'b1;
                lwr_en = 1'b1;
                lwr_data = spq_pkg::NIL;
                // link old tail to us; the old tail's link is written next cycle
                if (qtail_reg[ch_reg] == spq_pkg::NIL)
                    qhead_next[ch_reg] = {1'b0, slot_reg};
                qtail_next[ch_reg] = {1'b0, slot_reg};
                qcnt_next[ch_reg]  = qcnt_reg[ch_reg] + 1'b1;
                state_next = spq_pkg::S_RDATA;
                victim_next = '0;
                tail_link_next = (qtail_reg[ch_reg] != spq_pkg::NIL);
                pay_next   = pay_reg;
                slot_next  = slot_reg;
                ts_next    = ts_reg;
                fp_next    = {{(64-PW){1'b0}}, qtail_reg[ch_reg]};
            end
            spq_pkg::S_RDATA:
            begin
                if (tail_link_reg)
                begin
                    lwr_en   = 1'b1;
                    lwr_addr = fp_reg[SW-1:0];
                    lwr_data = {1'b0, slot_reg};
                end
                fp_next    = '0;
                state_next = spq_pkg::S_OUT;
            end
            spq_pkg::S_READ:
            begin
                frd_addr   = slot_reg;
                state_next = spq_pkg::S_READ;
                st_next    = spq_pkg::ST_DONE;
                if (st_reg == spq_pkg::ST_DONE)
                begin
                    fp_next    = frd_pay;
                    fs_next    = frd_len;
                    ft_next    = frd_time;
                    state_next = spq_pkg::S_OUT;
                end
            end
            spq_pkg::S_OUT:
            begin
                // hold until the output register is free
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next = 1'b1;
                    anyp_next   = used_reg != '0;
                    chp_next    = qcnt_reg[ch_reg] != '0;
                    ost_next    = st_reg;
                    oev_next    = ev_reg;
                    ogr_next    = gr_reg;
                    ofp_next    = fp_reg;
                    ofs_next    = fs_reg;
                    oft_next    = ft_reg;
                    state_next  = spq_pkg::S_IDLE;
                end
            end
            default: state_next = spq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= spq_pkg::S_INIT;
            qhead_reg  <= {NCH{spq_pkg::NIL}};
            qtail_reg  <= {NCH{spq_pkg::NIL}};
            qcnt_reg   <= '0;
            free_reg   <= '0;
            used_reg   <= '0;
            cursor_reg <= '0;
            init_reg   <= '0;
            ovalid_reg <= 1'b0;
            mode_reg   <= '0;
            st_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            qhead_reg  <= qhead_next;
            qtail_reg  <= qtail_next;
            qcnt_reg   <= qcnt_next;
            free_reg   <= free_next;
            used_reg   <= used_next;
            cursor_reg <= cursor_next;
            init_reg   <= init_next;
            ovalid_reg <= ovalid_next;
            mode_reg   <= mode_next;
            st_reg     <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg     <= ch_next;
        pay_reg    <= pay_next;
        len_reg    <= len_next;
        ts_reg     <= ts_next;
        victim_reg <= victim_next;
        slot_reg   <= slot_next;
        ev_reg     <= ev_next;
        gr_reg     <= gr_next;
        fp_reg     <= fp_next;
        fs_reg     <= fs_next;
        ft_reg     <= ft_next;
        tail_link_reg <= tail_link_next;
        anyp_reg   <= anyp_next;
        chp_reg    <= chp_next;
        ost_reg    <= ost_next;
        oev_reg    <= oev_next;
        ogr_reg    <= ogr_next;
        ofp_reg    <= ofp_next;
        ofs_reg    <= ofs_next;
        oft_reg    <= oft_next;
    end

    assign out_valid       = ovalid_reg;
    assign status          = ost_reg;
    assign victim_channel  = oev_reg;
    assign granted_channel = ogr_reg;
    assign front_payload   = ofp_reg;
    assign front_size      = ofs_reg;
    assign front_time      = oft_reg;
    assign any_pending     = anyp_reg;
    assign channel_pending = chp_reg;
endmodule

// ===== sv/spq_scan.sv =====
`timescale 1ns / 1ps
// Channel scan unit: steps over the channels one per cycle, finding the fullest
// channel or the next non-empty one from a cursor. Uses spq_pkg.
module spq_scan (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           start,
    input  logic                                           find_max,
    input  logic [spq_pkg::CW-1:0]                         cursor,
    input  logic [spq_pkg::CHANNEL_COUNT-1:0][spq_pkg::QCW-1:0] counts,
    output logic                                           done,
    output logic                                           found,
    output logic [spq_pkg::CW-1:0]                         result
);
    localparam int IW = $clog2(spq_pkg::CHANNEL_COUNT + 1);
    logic                     busy_reg, busy_next;
    logic [IW-1:0]            step_reg, step_next;
    logic [spq_pkg::CW-1:0]   cand_reg, cand_next;
    logic [spq_pkg::QCW-1:0]  best_reg, best_next;
    logic                     found_reg, found_next;
    logic                     mode_reg, mode_next;
    logic [spq_pkg::CW-1:0]   res_reg, res_next;
    logic [spq_pkg::QCW-1:0]  cnt;

    assign cnt = counts[cand_reg];

    always_comb
    begin
        busy_next  = busy_reg;
        step_next  = step_reg;
        cand_next  = cand_reg;
        best_next  = best_reg;
        found_next = found_reg;
        mode_next  = mode_reg;
        res_next   = res_reg;
        done       = 1'b0;
        if (start)
        begin
            busy_next  = 1'b1;
            step_next  = '0;
            cand_next  = find_max ? '0 : cursor;
            best_next  = '0;
            found_next = 1'b0;
            mode_next  = find_max;
            res_next   = '0;
        end
        else if (busy_reg)
        begin
            if (mode_reg)
            begin
                if (cnt > best_reg)
                begin
                    best_next = cnt;
                    res_next  = cand_reg;
                end
            end
            else if (!found_reg && cnt != '0)
            begin
                found_next = 1'b1;
                res_next   = cand_reg;
            end
            cand_next = (cand_reg == spq_pkg::CW'(spq_pkg::CHANNEL_COUNT - 1))
                ? '0 : cand_reg + 1'b1;
            step_next = step_reg + 1'b1;
            if (step_reg == IW'(spq_pkg::CHANNEL_COUNT - 1))
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= '0;
            cand_reg  <= '0;
            best_reg  <= '0;
            found_reg <= 1'b0;
            mode_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            step_reg  <= step_next;
            cand_reg  <= cand_next;
            best_reg  <= best_next;
            found_reg <= found_next;
            mode_reg  <= mode_next;
            res_reg   <= res_next;
        end
    end

    // done pulses while the last candidate is folded in, so take the next values
    assign found  = found_next;
    assign result = res_next;
endmodule
